>>> rtl/ptng_pkg.sv
// shared types, register map, note frequency table and codes for the pitch to note gate
`timescale 1ns / 1ps
`default_nettype none

package ptng_pkg;

    localparam int CNT_W_DEFAULT = 8;

    localparam int FREQ_W  = 18;
    localparam int VOL_W   = 16;
    localparam int NOTE_W  = 8;
    localparam int IDX_W   = 8;
    localparam int PC_W    = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [NOTE_W-1:0] NO_NOTE   = 8'hFF;
    localparam logic [IDX_W-1:0]  FIRST_IDX = 8'd1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = 8'd129;
    localparam logic [NOTE_W-1:0] TOP_NOTE  = 8'd128;
    localparam logic [PC_W-1:0]   PC_LAST   = 4'd11;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LOUD_LEVEL    = 3'd0;
    localparam logic [2:0] REG_BRIDGE_FRAMES = 3'd1;
    localparam logic [2:0] REG_ONSET_FRAMES  = 3'd2;
    localparam logic [2:0] REG_RELEASE       = 3'd3;
    localparam logic [2:0] REG_PC_MASK       = 3'd4;
    localparam logic [2:0] REG_HIGHEST       = 3'd5;
    localparam logic [2:0] REG_LOWEST        = 3'd6;

    // boundary position between two kept notes
    localparam logic [1:0] RATIO_MID  = 2'd0;
    localparam logic [1:0] RATIO_UP   = 2'd1;
    localparam logic [1:0] RATIO_DOWN = 2'd2;

    typedef struct packed {
        logic [15:0] loud_level;
        logic [7:0]  bridge_frames;
        logic [7:0]  onset_hold_frames;
        logic [7:0]  release_frames;
        logic [11:0] pitch_class_mask;
        logic [6:0]  highest_note;
        logic [6:0]  lowest_note;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } sts_t;

    // entry 0 bottom sentinel, entries 1..128 notes 0..127, entry 129 top sentinel
    localparam logic [FREQ_W-1:0] NOTE_FREQ [0:129] = '{
        18'd77,
        18'd82, 18'd87, 18'd92, 18'd97, 18'd103, 18'd109, 18'd116, 18'd122,
        18'd130, 18'd138, 18'd146, 18'd154,
        18'd164, 18'd173, 18'd184, 18'd194, 18'd206, 18'd218, 18'd231, 18'd245,
        18'd260, 18'd275, 18'd291, 18'd309,
        18'd327, 18'd346, 18'd367, 18'd389, 18'd412, 18'd437, 18'd462, 18'd490,
        18'd519, 18'd550, 18'd583, 18'd617,
        18'd654, 18'd693, 18'd734, 18'd778, 18'd824, 18'd873, 18'd925, 18'd980,
        18'd1038, 18'd1100, 18'd1165, 18'd1235,
        18'd1308, 18'd1386, 18'd1468, 18'd1556, 18'd1648, 18'd1746, 18'd1850,
        18'd1960, 18'd2077, 18'd2200, 18'd2331, 18'd2469,
        18'd2616, 18'd2772, 18'd2937, 18'd3111, 18'd3296, 18'd3492, 18'd3700,
        18'd3920, 18'd4153, 18'd4400, 18'd4662, 18'd4939,
        18'd5233, 18'd5544, 18'd5873, 18'd6223, 18'd6593, 18'd6985, 18'd7400,
        18'd7840, 18'd8306, 18'd8800, 18'd9323, 18'd9878,
        18'd10465, 18'd11087, 18'd11747, 18'd12445, 18'd13185, 18'd13969,
        18'd14800, 18'd15680, 18'd16612, 18'd17600, 18'd18647, 18'd19755,
        18'd20930, 18'd22175, 18'd23493, 18'd24890, 18'd26370, 18'd27938,
        18'd29600, 18'd31360, 18'd33224, 18'd35200, 18'd37293, 18'd39511,
        18'd41860, 18'd44349, 18'd46986, 18'd49780, 18'd52740, 18'd55877,
        18'd59199, 18'd62719, 18'd66449, 18'd70400, 18'd74586, 18'd79021,
        18'd83720, 18'd88698, 18'd93973, 18'd99561, 18'd105481, 18'd111753,
        18'd118398, 18'd125439,
        18'd132898
    };

    function automatic logic [FREQ_W-1:0] note_freq(input logic [IDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        f = '0;
        if (idx <= LAST_IDX)
        begin
            f = NOTE_FREQ[idx];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ptng_in_if.sv
// input channel: one frame per beat
`timescale 1ns / 1ps
`default_nettype none

interface ptng_in_if;
    import ptng_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] pitch_tenth_hz;
    logic [VOL_W-1:0]  frame_volume;
    logic [NOTE_W-1:0] playing_note;

    modport source (output valid, pitch_tenth_hz, frame_volume, playing_note, input ready);
    modport sink (input valid, pitch_tenth_hz, frame_volume, playing_note, output ready);
endinterface

`default_nettype wire

>>> rtl/ptng_out_if.sv
// output channel: one result per beat
`timescale 1ns / 1ps
`default_nettype none

interface ptng_out_if;
    import ptng_pkg::*;

    logic              valid;
    logic              ready;
    logic [NOTE_W-1:0] quantized_note;
    logic [NOTE_W-1:0] gated_note;

    modport source (output valid, quantized_note, gated_note, input ready);
    modport sink (input valid, quantized_note, gated_note, output ready);
endinterface

`default_nettype wire

>>> rtl/ptng_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none

module ptng_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptng_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ptng_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ptng_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output ptng_pkg::cfg_t                      cfg
);
    import ptng_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_LOUD_LEVEL:    cfg_next.loud_level        = pwdata[15:0];
                REG_BRIDGE_FRAMES: cfg_next.bridge_frames     = pwdata[7:0];
                REG_ONSET_FRAMES:  cfg_next.onset_hold_frames = pwdata[7:0];
                REG_RELEASE:       cfg_next.release_frames    = pwdata[7:0];
                REG_PC_MASK:       cfg_next.pitch_class_mask  = pwdata[11:0];
                REG_HIGHEST:       cfg_next.highest_note      = pwdata[6:0];
                REG_LOWEST:        cfg_next.lowest_note       = pwdata[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_LOUD_LEVEL:    prdata = {16'd0, cfg_reg.loud_level};
            REG_BRIDGE_FRAMES: prdata = {24'd0, cfg_reg.bridge_frames};
            REG_ONSET_FRAMES:  prdata = {24'd0, cfg_reg.onset_hold_frames};
            REG_RELEASE:       prdata = {24'd0, cfg_reg.release_frames};
            REG_PC_MASK:       prdata = {20'd0, cfg_reg.pitch_class_mask};
            REG_HIGHEST:       prdata = {25'd0, cfg_reg.highest_note};
            REG_LOWEST:        prdata = {25'd0, cfg_reg.lowest_note};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loud_level        <= 16'd300;
            cfg_reg.bridge_frames     <= 8'd5;
            cfg_reg.onset_hold_frames <= 8'd3;
            cfg_reg.release_frames    <= 8'd3;
            cfg_reg.pitch_class_mask  <= 12'hFFF;
            cfg_reg.highest_note      <= 7'd127;
            cfg_reg.lowest_note       <= 7'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptng_ctrl.sv
// controller: sequences load, table walk and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module ptng_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  ptng_pkg::sts_t      sts,
    output ptng_pkg::cmd_t      cmd
);
    import ptng_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // the output slot frees in the same cycle its beat is taken
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptng_dp.sv
// datapath: note table walk with hysteresis boundary, range check and volume gating
`timescale 1ns / 1ps
`default_nettype none

module ptng_dp #(
    parameter int COUNT_WIDTH = ptng_pkg::CNT_W_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  ptng_pkg::cfg_t                      cfg,
    input  ptng_pkg::cmd_t                      cmd,
    output ptng_pkg::sts_t                      sts,
    input  wire logic [ptng_pkg::FREQ_W-1:0]    pitch_tenth_hz,
    input  wire logic [ptng_pkg::VOL_W-1:0]     frame_volume,
    input  wire logic [ptng_pkg::NOTE_W-1:0]    playing_note,
    output logic      [ptng_pkg::NOTE_W-1:0]    quantized_note,
    output logic      [ptng_pkg::NOTE_W-1:0]    gated_note
);
    import ptng_pkg::*;

    localparam int CMPX_W = FREQ_W + 4;

    // frame payload
    logic [FREQ_W-1:0]      freq_reg;
    logic [VOL_W-1:0]       vol_reg;
    logic [NOTE_W-1:0]      play_reg;
    logic [1:0]             mode_reg;
    logic [1:0]             mode_next;

    // walk state
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [PC_W-1:0]        pc_reg;
    logic [PC_W-1:0]        pc_next;
    logic [IDX_W-1:0]       lo_idx_reg;
    logic [IDX_W-1:0]       lo_idx_next;
    logic [FREQ_W-1:0]      lo_freq_reg;
    logic [FREQ_W-1:0]      lo_freq_next;

    // frame counters
    logic [COUNT_WIDTH-1:0] bridge_cnt_reg;
    logic [COUNT_WIDTH-1:0] bridge_cnt_next;
    logic [COUNT_WIDTH-1:0] loud_cnt_reg;
    logic [COUNT_WIDTH-1:0] loud_cnt_next;
    logic [COUNT_WIDTH-1:0] quiet_cnt_reg;
    logic [COUNT_WIDTH-1:0] quiet_cnt_next;

    logic [NOTE_W-1:0]      qnote_reg;
    logic [NOTE_W-1:0]      qnote_next;
    logic [NOTE_W-1:0]      gnote_reg;
    logic [NOTE_W-1:0]      gnote_next;

    logic [FREQ_W-1:0]      cur_freq;
    logic [FREQ_W-1:0]      entry_freq;
    logic [FREQ_W-1:0]      gap;
    logic [FREQ_W-1:0]      offset;
    logic [FREQ_W:0]        offset_inc;
    logic [CMPX_W-1:0]      lhs;
    logic [CMPX_W-1:0]      rhs;
    logic                   kept;
    logic                   below;
    logic                   stop;

    logic [NOTE_W-1:0]      cand;
    logic [NOTE_W-1:0]      note;
    logic                   loud;
    logic [NOTE_W-1:0]      ret;

    // frequency of the playing note picks the boundary position
    always_comb
    begin
        cur_freq  = note_freq(playing_note + 8'd1);
        mode_next = RATIO_MID;
        if (playing_note <= TOP_NOTE)
        begin
            mode_next = (pitch_tenth_hz > cur_freq) ? RATIO_UP : RATIO_DOWN;
        end
    end

    // freq < lower + floor(gap * r / 100) rewritten without a divide:
    // freq below lower, or 100 * (freq - lower + 1) <= gap * r
    always_comb
    begin
        entry_freq = note_freq(idx_reg);
        kept       = cfg.pitch_class_mask[pc_reg];
        gap        = entry_freq - lo_freq_reg;
        offset     = freq_reg - lo_freq_reg;
        offset_inc = {1'b0, offset} + {{FREQ_W{1'b0}}, 1'b1};
        case (mode_reg)
            RATIO_MID:
            begin
                lhs = {2'b00, offset_inc, 1'b0};
                rhs = {4'd0, gap};
            end
            RATIO_UP:
            begin
                lhs = {1'b0, offset_inc, 2'b00} + {3'd0, offset_inc};
                rhs = {2'b00, gap, 2'b00};
            end
            default:
            begin
                lhs = {1'b0, offset_inc, 2'b00} + {3'd0, offset_inc};
                rhs = {4'd0, gap};
            end
        endcase
        below = (freq_reg < lo_freq_reg) || (lhs <= rhs);
        stop  = kept && below;
        sts.walk_done = stop || (idx_reg == LAST_IDX);
    end

    always_comb
    begin
        idx_next     = idx_reg;
        pc_next      = pc_reg;
        lo_idx_next  = lo_idx_reg;
        lo_freq_next = lo_freq_reg;
        if (cmd.load)
        begin
            idx_next     = FIRST_IDX;
            pc_next      = '0;
            lo_idx_next  = '0;
            lo_freq_next = note_freq('0);
        end
        else if (cmd.walk)
        begin
            idx_next = idx_reg + 8'd1;
            pc_next  = (pc_reg == PC_LAST) ? '0 : pc_reg + 4'd1;
            if (kept && !below)
            begin
                lo_idx_next  = idx_reg;
                lo_freq_next = entry_freq;
            end
        end
    end

    // range check, then gating; top sentinel lands above any highest note
    always_comb
    begin
        cand = lo_idx_reg - 8'd1;
        note = NO_NOTE;
        if ((lo_idx_reg != '0) && (cand >= {1'b0, cfg.lowest_note})
            && (cand <= {1'b0, cfg.highest_note}))
        begin
            note = cand;
        end
        loud = (vol_reg >= cfg.loud_level);
        ret  = note;

        bridge_cnt_next = bridge_cnt_reg;
        loud_cnt_next   = loud_cnt_reg;
        quiet_cnt_next  = quiet_cnt_reg;

        if ((note == NO_NOTE) && loud)
        begin
            if ({8'd0, bridge_cnt_reg} < {{COUNT_WIDTH{1'b0}}, cfg.bridge_frames})
            begin
                bridge_cnt_next = (&bridge_cnt_reg) ? bridge_cnt_reg : bridge_cnt_reg + 1'b1;
                ret             = play_reg;
            end
        end
        else
        begin
            bridge_cnt_next = '0;
        end

        if (!loud)
        begin
            loud_cnt_next = '0;
            if ({8'd0, quiet_cnt_reg} < {{COUNT_WIDTH{1'b0}}, cfg.release_frames})
            begin
                ret = play_reg;
            end
            quiet_cnt_next = (&quiet_cnt_reg) ? quiet_cnt_reg : quiet_cnt_reg + 1'b1;
        end
        else
        begin
            if ({8'd0, loud_cnt_reg} < {{COUNT_WIDTH{1'b0}}, cfg.onset_hold_frames})
            begin
                ret = NO_NOTE;
            end
            loud_cnt_next  = (&loud_cnt_reg) ? loud_cnt_reg : loud_cnt_reg + 1'b1;
            quiet_cnt_next = '0;
        end

        qnote_next = note;
        gnote_next = ret;
    end

    assign quantized_note = qnote_reg;
    assign gated_note     = gnote_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg <= pitch_tenth_hz;
            vol_reg  <= frame_volume;
            play_reg <= playing_note;
            mode_reg <= mode_next;
        end
        idx_reg     <= idx_next;
        pc_reg      <= pc_next;
        lo_idx_reg  <= lo_idx_next;
        lo_freq_reg <= lo_freq_next;
        if (cmd.finish)
        begin
            qnote_reg <= qnote_next;
            gnote_reg <= gnote_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_cnt_reg <= '0;
            loud_cnt_reg   <= '0;
            quiet_cnt_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            bridge_cnt_reg <= bridge_cnt_next;
            loud_cnt_reg   <= loud_cnt_next;
            quiet_cnt_reg  <= quiet_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pitch_to_note_gate_core.sv
// top level of the pitch to note gate
//
// usage:
//   in_ch carries one frame per beat: pitch estimate in 0.1 hz units, frame volume and
//   the note now sounding (255 for none). out_ch returns one beat per frame with the
//   table lookup note and the gated note (255 for none); pready is always high. registers
//   must be written over the apb port while the block is idle, which it does not enforce.
// timing:
//   a frame walks the note table one entry a cycle through a single boundary compare,
//   stopping at the first kept entry the pitch falls below. a frame that stops at entry
//   k (1 to 129) then passes through the finish state, which waits for a free output
//   slot, before out_ch.valid rises. one frame is in flight at a time; in_ch.ready is
//   high only while idle, so a new frame is taken only after the last one has finished.
// stall:
//   the result sits in an output register; a new frame is accepted while it waits, and
//   the next result is held back until the waiting beat is taken.
// reset:
//   rst_n clears the frame counters, the controller and the output valid, and loads the
//   register defaults. no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pitch_to_note_gate_core #(
    parameter int COUNT_WIDTH = ptng_pkg::CNT_W_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ptng_in_if.sink                             in_ch,
    ptng_out_if.source                          out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptng_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ptng_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ptng_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import ptng_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    ptng_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptng_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .pitch_tenth_hz (in_ch.pitch_tenth_hz),
        .frame_volume   (in_ch.frame_volume),
        .playing_note   (in_ch.playing_note),
        .quantized_note (out_ch.quantized_note),
        .gated_note     (out_ch.gated_note)
    );

    // one frame at a time: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while a frame is in flight");

    // every finished frame shows up on the output
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_ch.valid)
        else $error("finished frame not presented");

    // output valid only rises from a finished frame
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.finish))
        else $error("output beat without a finished frame");

    // walking never overlaps an accept
    a_no_walk_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.walk && !cmd.finish)
        else $error("load overlaps walk or finish");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the pitch to note gate: note lookup, hysteresis and volume gating
`timescale 1ns / 1ps

module tb;
    import ptng_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 140;

    // boundary position between kept notes, in percent of the gap
    localparam int unsigned SPLIT_MID  = 50;
    localparam int unsigned SPLIT_UP   = 80;
    localparam int unsigned SPLIT_DOWN = 20;
    localparam int unsigned PERCENT    = 100;
    localparam int unsigned TABLE_SIZE = 130;

    typedef struct {
        logic [NOTE_W-1:0] quantized;
        logic [NOTE_W-1:0] gated;
    } note_pair_t;

    class note_gate_scoreboard;
        cfg_t              cfg;
        logic [7:0]        bridge_cnt;
        logic [7:0]        loud_cnt;
        logic [7:0]        quiet_cnt;
        note_pair_t        pending_notes[$];
        int                errors;
        int                frames;
        int                results;
        int                found;
        int                gated;

        function new();
            cfg.loud_level        = 16'd300;
            cfg.bridge_frames     = 8'd5;
            cfg.onset_hold_frames = 8'd3;
            cfg.release_frames    = 8'd3;
            cfg.pitch_class_mask  = 12'hFFF;
            cfg.highest_note      = 7'd127;
            cfg.lowest_note       = 7'd0;
            bridge_cnt = '0;
            loud_cnt   = '0;
            quiet_cnt  = '0;
            errors     = 0;
            frames     = 0;
            results    = 0;
            found      = 0;
            gated      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_LOUD_LEVEL:    cfg.loud_level        = val[15:0];
                REG_BRIDGE_FRAMES: cfg.bridge_frames     = val[7:0];
                REG_ONSET_FRAMES:  cfg.onset_hold_frames = val[7:0];
                REG_RELEASE:       cfg.release_frames    = val[7:0];
                REG_PC_MASK:       cfg.pitch_class_mask  = val[11:0];
                REG_HIGHEST:       cfg.highest_note      = val[6:0];
                REG_LOWEST:        cfg.lowest_note       = val[6:0];
                default:           ;
            endcase
        endfunction

        function logic [7:0] sat_inc(logic [7:0] c);
            return (c == 8'hFF) ? c : c + 8'd1;
        endfunction

        // walk the note table, keeping the last entry whose boundary the pitch reached
        function logic [NOTE_W-1:0] quantize(logic [FREQ_W-1:0] freq, logic [NOTE_W-1:0] playing);
            int unsigned cur;
            int unsigned lower;
            int unsigned idx;
            int unsigned ratio;
            int unsigned bound;
            int unsigned pn;
            cur   = 0;
            lower = 0;
            pn    = playing;
            if (pn + 1 < TABLE_SIZE)
            begin
                cur = NOTE_FREQ[pn + 1];
            end
            for (idx = 1; idx < TABLE_SIZE; idx++)
            begin
                if (!cfg.pitch_class_mask[(idx - 1) % 12])
                begin
                    continue;
                end
                if (cur == 0)
                begin
                    ratio = SPLIT_MID;
                end
                else if (freq > cur)
                begin
                    ratio = SPLIT_UP;
                end
                else
                begin
                    ratio = SPLIT_DOWN;
                end
                bound = int'(NOTE_FREQ[lower])
                      + (int'(NOTE_FREQ[idx]) - int'(NOTE_FREQ[lower])) * ratio / PERCENT;
                if (freq < bound)
                begin
                    break;
                end
                lower = idx;
            end
            if (lower == 0)
            begin
                return NO_NOTE;
            end
            if (lower - 1 >= cfg.lowest_note && lower - 1 <= cfg.highest_note)
            begin
                return 8'(lower - 1);
            end
            return NO_NOTE;
        endfunction

        function void note_frame(logic [FREQ_W-1:0] freq, logic [VOL_W-1:0] vol,
                                 logic [NOTE_W-1:0] playing);
            logic [NOTE_W-1:0] note;
            logic [NOTE_W-1:0] ret;
            logic              loud;
            note_pair_t        e;
            note = quantize(freq, playing);
            ret  = note;
            loud = (vol >= cfg.loud_level);
            // bridge a dropout while the sound stays loud
            if (note == NO_NOTE && loud)
            begin
                if (bridge_cnt < cfg.bridge_frames)
                begin
                    bridge_cnt = sat_inc(bridge_cnt);
                    ret = playing;
                end
            end
            else
            begin
                bridge_cnt = '0;
            end
            if (!loud)
            begin
                loud_cnt = '0;
                if (quiet_cnt < cfg.release_frames)
                begin
                    ret = playing;
                end
                quiet_cnt = sat_inc(quiet_cnt);
            end
            else
            begin
                if (loud_cnt < cfg.onset_hold_frames)
                begin
                    ret = NO_NOTE;
                end
                loud_cnt  = sat_inc(loud_cnt);
                quiet_cnt = '0;
            end
            e.quantized = note;
            e.gated     = ret;
            pending_notes.push_back(e);
            frames++;
            if (note != NO_NOTE)
            begin
                found++;
            end
            if (ret != NO_NOTE)
            begin
                gated++;
            end
        endfunction

        function void check_result(logic [NOTE_W-1:0] q, logic [NOTE_W-1:0] g);
            note_pair_t e;
            results++;
            if (pending_notes.size() == 0)
            begin
                $error("result with nothing expected: quantized_note %0d gated_note %0d", q, g);
                errors++;
                return;
            end
            e = pending_notes.pop_front();
            if (q !== e.quantized)
            begin
                $error("quantized_note expected %0d actual %0d", e.quantized, q);
                errors++;
            end
            if (g !== e.gated)
            begin
                $error("gated_note expected %0d actual %0d", e.gated, g);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ptng_in_if  in_if ();
    ptng_out_if out_if ();

    note_gate_scoreboard sb;

    int  burst_left;
    int  settings_done;
    bit  hold_req;
    int  idle_cycles;

    pitch_to_note_gate_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_settings(int unsigned level, int unsigned bridge, int unsigned onset,
                                  int unsigned release_n, int unsigned mask,
                                  int unsigned hi, int unsigned lo);
        write_reg(REG_LOUD_LEVEL, level);
        write_reg(REG_BRIDGE_FRAMES, bridge);
        write_reg(REG_ONSET_FRAMES, onset);
        write_reg(REG_RELEASE, release_n);
        write_reg(REG_PC_MASK, mask);
        write_reg(REG_HIGHEST, hi);
        write_reg(REG_LOWEST, lo);
        settings_done++;
    endtask

    // offer one frame; the sender runs in bursts with random gaps between them
    task automatic send_frame(logic [FREQ_W-1:0] p, logic [VOL_W-1:0] v, logic [NOTE_W-1:0] n);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                @(negedge clk);
                in_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        in_if.valid          = 1'b1;
        in_if.pitch_tenth_hz = p;
        in_if.frame_volume   = v;
        in_if.playing_note   = n;
        do
        begin
            @(posedge clk);
        end
        while (!in_if.ready);
        sb.note_frame(p, v, n);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_if.valid = 1'b0;
        burst_left  = 0;
        while (sb.pending_notes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_pitch(int idx);
        int r;
        int base;
        int span;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 18'($urandom_range(0, 262143));
        end
        // pitch at or near the bottom sentinel, or past the top sentinel
        if (r < 20)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                return 18'($urandom_range(0, 78));
            end
            return 18'($urandom_range(140000, 262143));
        end
        base = NOTE_FREQ[idx];
        span = base / 8 + 2;
        return 18'(base - span + int'($urandom_range(0, 2 * span)));
    endfunction

    function automatic logic [VOL_W-1:0] pick_volume(bit loud);
        int unsigned level;
        level = sb.cfg.loud_level;
        if ($urandom_range(0, 19) == 0)
        begin
            return 16'($urandom_range(0, 65535));
        end
        if (loud)
        begin
            if (level == 65535 || $urandom_range(0, 3) == 0)
            begin
                return 16'(level);
            end
            return 16'($urandom_range(level, 65535));
        end
        if (level == 0)
        begin
            return 16'($urandom_range(0, 65535));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'(level - 1);
        end
        return 16'($urandom_range(0, level - 1));
    endfunction

    function automatic logic [NOTE_W-1:0] pick_playing(int idx);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            // neighbour of the sung note, so the hysteresis boundaries get used
            n = idx - 2 + int'($urandom_range(0, 2));
            if (n < 0)
            begin
                n = 0;
            end
            if (n > 127)
            begin
                n = 127;
            end
            return 8'(n);
        end
        if (r < 60)
        begin
            return NO_NOTE;
        end
        if (r < 70)
        begin
            return 8'($urandom_range(128, 254));
        end
        return 8'($urandom_range(0, 127));
    endfunction

    // segments of steady loud or quiet sound around one note, with dropouts and jitter
    task automatic run_random_phase(int n_items);
        int                sent;
        int                seg_len;
        int                k;
        int                idx;
        bit                loud;
        logic [NOTE_W-1:0] playing;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(1, 12);
            loud    = ($urandom_range(0, 9) < 6);
            idx     = $urandom_range(0, 129);
            playing = pick_playing(idx);
            for (k = 0; k < seg_len && sent < n_items; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    playing = 8'($urandom_range(0, 255));
                end
                send_frame(pick_pitch(idx), pick_volume(loud), playing);
                sent++;
            end
        end
    endtask

    // long runs drive the frame counters into saturation
    task automatic long_run(bit loud, int len);
        int                k;
        logic [NOTE_W-1:0] playing;
        playing = 8'($urandom_range(0, 127));
        for (k = 0; k < len; k++)
        begin
            if (loud)
            begin
                send_frame(18'($urandom_range(0, 78)), pick_volume(1'b1), playing);
            end
            else
            begin
                send_frame(pick_pitch($urandom_range(1, 128)), pick_volume(1'b0), playing);
            end
        end
    endtask

    task automatic run_directed();
        send_frame(18'd0,      16'd0,     8'd255);
        send_frame(18'd262143, 16'd65535, 8'd0);
        send_frame(18'd4400,   16'd300,   8'd255);
        send_frame(18'd4400,   16'd299,   8'd69);
        send_frame(18'd78,     16'd1000,  8'd60);
        send_frame(18'd4400,   16'd1000,  8'd69);
        send_frame(18'd4400,   16'd1000,  8'd69);
        send_frame(18'd4400,   16'd1000,  8'd69);
        // rising and falling around the playing note
        send_frame(18'd4600,   16'd1000,  8'd69);
        send_frame(18'd4210,   16'd1000,  8'd69);
        send_frame(18'd4530,   16'd1000,  8'd255);
        send_frame(18'd132898, 16'd1000,  8'd128);
        send_frame(18'd5000,   16'd1000,  8'd200);
        send_frame(18'd77,     16'd1000,  8'd129);
        send_frame(18'd100000, 16'd1000,  8'd127);
        send_frame(18'd0,      16'd1000,  8'd50);
        send_frame(18'd0,      16'd1000,  8'd50);
        send_frame(18'd0,      16'd1000,  8'd50);
        send_frame(18'd82,     16'd65535, 8'd0);
        send_frame(18'd125439, 16'd65534, 8'd254);
        send_frame(18'd125439, 16'd0,     8'd254);
        send_frame(18'd262143, 16'd0,     8'd128);
    endtask

    // receiver: own stall pattern plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int mode_left;
        int rx_mode;
        int pat_cnt;
        hold_left    = 0;
        mode_left    = 0;
        rx_mode      = 0;
        pat_cnt      = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_if.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (rx_mode)
                    0:       out_if.ready = 1'b1;
                    1:       out_if.ready = 1'($urandom_range(0, 1));
                    2:       out_if.ready = ((pat_cnt % 5) != 0);
                    default: out_if.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
            pat_cnt++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            sb.check_result(out_if.quantized_note, out_if.gated_note);
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        sb                   = new();
        burst_left           = 0;
        settings_done        = 0;
        hold_req             = 1'b0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_if.valid          = 1'b0;
        in_if.pitch_tenth_hz = '0;
        in_if.frame_volume   = '0;
        in_if.playing_note   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_drained();

        for (ph = 1; ph <= 8; ph++)
        begin
            case (ph)
                1: apply_settings(0, 0, 0, 0, 12'hFFF, 127, 0);
                2: apply_settings(65535, 255, 255, 255, 12'h000, 0, 127);
                3: apply_settings(1000, 3, 2, 4, 12'hAB5, 100, 20);
                // lowest above highest: no note ever passes the range check
                4: apply_settings(500, 2, 1, 2, 12'hFFF, 40, 60);
                // top sentinel skipped by the mask
                5: apply_settings(300, 6, 0, 1, 12'hEFF, 127, 0);
                6: apply_settings(2000, 255, 254, 255, 12'hFFF, 127, 0);
                7: apply_settings($urandom_range(0, 65535), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 4095), $urandom_range(0, 127),
                                  $urandom_range(0, 127));
                default: apply_settings(100, 1, 1, 1, 12'h100, 127, 0);
            endcase
            if (ph == 3)
            begin
                hold_req = 1'b1;
            end
            if (ph == 6)
            begin
                long_run(1'b1, 265);
                long_run(1'b0, 262);
                run_random_phase(30);
            end
            else
            begin
                run_random_phase(70);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_notes.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_notes.size());
            sb.errors++;
        end
        $display("frames %0d, results %0d, register settings %0d", sb.frames, sb.results,
                 settings_done + 1);
        $display("lookups with a note %0d, gated beats carrying a note %0d", sb.found,
                 sb.gated);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/ptng_pkg.sv
rtl/ptng_in_if.sv
rtl/ptng_out_if.sv
rtl/ptng_regs.sv
rtl/ptng_ctrl.sv
rtl/ptng_dp.sv
rtl/pitch_to_note_gate_core.sv
tb/tb.sv
